// File: src/imap_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// imap_pkg
// Shared codes for the interval map: item actions and result status.
// ----------------------------------------------------------------------------
package imap_pkg;

    // item action
    typedef enum logic {
        ACT_ASSIGN = 1'b0,
        ACT_LOOKUP = 1'b1
    } action_t;

    // result status
    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

endpackage
`default_nettype wire

// File: src/imap_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// imap_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module imap_ram #(
    parameter int WIDTH = 40,
    parameter int DEPTH = 64
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output      logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write and registered read
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule
`default_nettype wire

// File: src/interval_map_range_assign_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// interval_map_range_assign_top
// Sorted breakpoint table in RAM with range assign and point lookup.
// ----------------------------------------------------------------------------
// Lookup: one scan pass over a table of N breakpoints (one RAM read per entry).
// Assign: one scan pass, then a shift pass of the entries that move, one RAM
// read and write per cycle, then up to two writes for the begin and end keys.
// Empty interval: no scan. One item in work at a time; a finished result
// waits in the output register while the next item is taken.
// Reset clears the count and default value; the RAM is not cleared.
// ----------------------------------------------------------------------------
module interval_map_range_assign_top
    import imap_pkg::*;
#(
    parameter int CAPACITY   = 64,
    parameter int KEY_BITS   = 32,
    parameter int VALUE_BITS = 8
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          cfg_wr_en,
    input  wire logic [VALUE_BITS-1:0]         cfg_wr_data,
    input  wire logic                          s_valid,
    output      logic                          s_ready,
    input  wire logic                          s_action,
    input  wire logic signed [KEY_BITS-1:0]    s_key_begin,
    input  wire logic signed [KEY_BITS-1:0]    s_key_end,
    input  wire logic [VALUE_BITS-1:0]         s_fill_value,
    input  wire logic signed [KEY_BITS-1:0]    s_query_key,
    output      logic                          m_valid,
    input  wire logic                          m_ready,
    output      logic [VALUE_BITS-1:0]         m_read_value,
    output      logic [1:0]                    m_status,
    output      logic [$clog2(CAPACITY+1)-1:0] m_entries_used
);

    localparam int ADDR_W = $clog2(CAPACITY);
    localparam int CNT_W  = $clog2(CAPACITY + 1);
    localparam int WK_W   = CNT_W + 2;
    localparam int RAM_W  = KEY_BITS + VALUE_BITS;

    typedef enum logic [2:0] {
        S_IDLE, S_SCAN, S_CALC, S_PRE, S_SUF, S_WB, S_WE, S_OUT
    } state_t;

    state_t state_reg;

    // item registers
    logic                         act_reg;
    logic signed [KEY_BITS-1:0]   kb_reg, ke_reg;
    logic [VALUE_BITS-1:0]        val_reg, dflt_reg;
    logic [CNT_W-1:0]             cnt_reg;

    // scan results
    logic [CNT_W-1:0]             iss_reg, ev_idx_reg, nlt_reg, idxgt_reg;
    logic                         ev_valid_reg, gtf_reg;
    logic [VALUE_BITS-1:0]        prev_reg, endv_reg, gtv_reg, v0_reg;

    // move engine and end writes
    logic [CNT_W-1:0]             mv_rem_reg, mv_src_reg;
    logic                         mv_up_reg;
    logic signed [CNT_W:0]        mv_off_reg;
    logic                         pend_reg;
    logic [ADDR_W-1:0]            pend_addr_reg;
    logic [CNT_W-1:0]             suf_src_reg, suf_len_reg, suf_dst_reg, new_cnt_reg;
    logic [CNT_W-1:0]             bpos_reg, epos_reg;
    logic                         bwr_reg, ewr_reg;

    // result
    logic                         m_valid_reg;
    logic [VALUE_BITS-1:0]        res_val_reg;
    status_t                      res_st_reg;
    status_t                      out_st_reg;
    logic [CNT_W-1:0]             out_cnt_reg;

    // RAM port
    logic                         ram_we;
    logic [ADDR_W-1:0]            ram_waddr, ram_raddr;
    logic [RAM_W-1:0]             ram_wdata, ram_rdata;
    logic signed [KEY_BITS-1:0]   ev_key;
    logic [VALUE_BITS-1:0]        ev_val;

    assign ev_key = ram_rdata[RAM_W-1:VALUE_BITS];
    assign ev_val = ram_rdata[VALUE_BITS-1:0];

    imap_ram #(
        .WIDTH(RAM_W),
        .DEPTH(CAPACITY)
    ) u_ram (
        .aclk   (aclk),
        .wr_en  (ram_we),
        .wr_addr(ram_waddr),
        .wr_data(ram_wdata),
        .rd_addr(ram_raddr),
        .rd_data(ram_rdata)
    );

    // plan the rewrite from the scan results
    logic                  c_kb, c_ke, c_first, c_full, c_hdrop, c_sdrop, c_bwr, c_ewr;
    logic [CNT_W-1:0]      c_nsuf, c_s0, c_bpos;
    logic [WK_W-1:0]       c_n, c_newn, c_d0, c_epos;
    logic [VALUE_BITS-1:0] c_w0;

    always_comb begin
        c_kb    = !(nlt_reg != '0 && prev_reg == val_reg);
        c_ke    = endv_reg != val_reg;
        c_nsuf  = cnt_reg - idxgt_reg;
        c_n     = WK_W'(nlt_reg) + WK_W'(c_kb) + WK_W'(c_ke) + WK_W'(c_nsuf);
        c_w0    = (nlt_reg != '0) ? v0_reg : c_kb ? val_reg : c_ke ? endv_reg : gtv_reg;
        c_first = (c_n != '0) && (c_w0 == dflt_reg);
        c_newn  = c_n - WK_W'(c_first);
        c_full  = c_newn > WK_W'(CAPACITY);
        c_hdrop = c_first && (nlt_reg == '0);
        c_sdrop = c_hdrop && !c_kb && !c_ke;
        c_s0    = idxgt_reg + CNT_W'(c_sdrop);
        c_d0    = WK_W'(nlt_reg) + WK_W'(c_kb) + WK_W'(c_ke) - WK_W'(c_first)
                  + WK_W'(c_sdrop);
        c_bpos  = nlt_reg - CNT_W'(c_first && nlt_reg != '0);
        c_bwr   = c_kb && !c_hdrop;
        c_epos  = WK_W'(nlt_reg) + WK_W'(c_kb) - WK_W'(c_first);
        c_ewr   = c_ke && !(c_hdrop && !c_kb);
    end

    // suffix move setup
    logic                  sf_up;
    logic signed [CNT_W:0] sf_off;

    assign sf_up  = suf_dst_reg < suf_src_reg;
    assign sf_off = $signed({1'b0, suf_dst_reg}) - $signed({1'b0, suf_src_reg});

    // move step: read source now, write it in the next cycle
    logic                  mv_issue;
    logic signed [CNT_W:0] mv_dst;

    assign mv_issue = (state_reg == S_PRE || state_reg == S_SUF) && mv_rem_reg != '0;
    assign mv_dst   = $signed({1'b0, mv_src_reg}) + mv_off_reg;

    // RAM read address and write port
    always_comb begin
        ram_raddr = (state_reg == S_SCAN) ? iss_reg[ADDR_W-1:0] : mv_src_reg[ADDR_W-1:0];
        ram_we    = 1'b0;
        ram_waddr = pend_addr_reg;
        ram_wdata = ram_rdata;
        if (pend_reg) begin
            ram_we = 1'b1;
        end else if (state_reg == S_WB) begin
            ram_we    = bwr_reg;
            ram_waddr = bpos_reg[ADDR_W-1:0];
            ram_wdata = {kb_reg, val_reg};
        end else if (state_reg == S_WE) begin
            ram_we    = ewr_reg;
            ram_waddr = epos_reg[ADDR_W-1:0];
            ram_wdata = {ke_reg, endv_reg};
        end
    end

    assign s_ready        = state_reg == S_IDLE;
    assign m_valid        = m_valid_reg;
    assign m_read_value   = res_val_reg;
    assign m_status       = out_st_reg;
    assign m_entries_used = out_cnt_reg;

    // sequencer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            cnt_reg      <= '0;
            dflt_reg     <= '0;
            m_valid_reg  <= 1'b0;
            pend_reg     <= 1'b0;
            ev_valid_reg <= 1'b0;
            mv_rem_reg   <= '0;
        end else begin
            if (cfg_wr_en) begin
                dflt_reg <= cfg_wr_data;
            end
            if (m_valid_reg && m_ready && state_reg != S_OUT) begin
                m_valid_reg <= 1'b0;
            end

            // drive the delayed move write
            pend_reg <= mv_issue;
            if (mv_issue) begin
                pend_addr_reg <= mv_dst[ADDR_W-1:0];
                mv_src_reg    <= mv_up_reg ? mv_src_reg + 1'b1 : mv_src_reg - 1'b1;
                mv_rem_reg    <= mv_rem_reg - 1'b1;
            end

            unique case (state_reg)
                S_IDLE: begin
                    if (s_valid) begin
                        act_reg      <= s_action;
                        kb_reg       <= s_key_begin;
                        ke_reg       <= (s_action == ACT_LOOKUP) ? s_query_key : s_key_end;
                        val_reg      <= s_fill_value;
                        iss_reg      <= '0;
                        ev_idx_reg   <= '0;
                        nlt_reg      <= '0;
                        idxgt_reg    <= '0;
                        gtf_reg      <= 1'b0;
                        endv_reg     <= dflt_reg;
                        prev_reg     <= '0;
                        gtv_reg      <= '0;
                        v0_reg       <= '0;
                        ev_valid_reg <= 1'b0;
                        if (s_action == ACT_ASSIGN && s_key_begin >= s_key_end) begin
                            res_st_reg <= ST_EMPTY;
                            state_reg  <= S_OUT;
                        end else begin
                            state_reg <= S_SCAN;
                        end
                    end
                end
                S_SCAN: begin
                    ev_valid_reg <= iss_reg < cnt_reg;
                    if (iss_reg < cnt_reg) begin
                        iss_reg <= iss_reg + 1'b1;
                    end
                    // fold one entry into the scan results
                    if (ev_valid_reg) begin
                        ev_idx_reg <= ev_idx_reg + 1'b1;
                        if (ev_idx_reg == '0) begin
                            v0_reg <= ev_val;
                        end
                        if (ev_key < kb_reg) begin
                            nlt_reg  <= nlt_reg + 1'b1;
                            prev_reg <= ev_val;
                        end
                        if (ev_key <= ke_reg) begin
                            endv_reg  <= ev_val;
                            idxgt_reg <= idxgt_reg + 1'b1;
                        end else if (!gtf_reg) begin
                            gtf_reg <= 1'b1;
                            gtv_reg <= ev_val;
                        end
                    end
                    if (iss_reg >= cnt_reg && !ev_valid_reg) begin
                        state_reg <= S_CALC;
                    end
                end
                S_CALC: begin
                    if (act_reg == ACT_LOOKUP) begin
                        res_st_reg <= ST_DONE;
                        state_reg  <= S_OUT;
                    end else if (c_full) begin
                        res_st_reg <= ST_FULL;
                        state_reg  <= S_OUT;
                    end else begin
                        res_st_reg  <= ST_DONE;
                        suf_src_reg <= c_s0;
                        suf_len_reg <= cnt_reg - c_s0;
                        suf_dst_reg <= c_d0[CNT_W-1:0];
                        new_cnt_reg <= c_newn[CNT_W-1:0];
                        bpos_reg    <= c_bpos;
                        epos_reg    <= c_epos[CNT_W-1:0];
                        bwr_reg     <= c_bwr;
                        ewr_reg     <= c_ewr;
                        // shift the prefix down when its head is dropped
                        mv_src_reg  <= CNT_W'(1);
                        mv_up_reg   <= 1'b1;
                        mv_off_reg  <= -(CNT_W+1)'(1);
                        mv_rem_reg  <= (c_first && nlt_reg != '0) ? nlt_reg - 1'b1 : '0;
                        state_reg   <= S_PRE;
                    end
                end
                S_PRE: begin
                    if (mv_rem_reg == '0 && !pend_reg) begin
                        mv_up_reg  <= sf_up;
                        mv_off_reg <= sf_off;
                        mv_src_reg <= sf_up ? suf_src_reg : suf_src_reg + suf_len_reg - 1'b1;
                        mv_rem_reg <= (suf_dst_reg == suf_src_reg) ? '0 : suf_len_reg;
                        state_reg  <= S_SUF;
                    end
                end
                S_SUF: begin
                    if (mv_rem_reg == '0 && !pend_reg) begin
                        state_reg <= S_WB;
                    end
                end
                S_WB: begin
                    state_reg <= S_WE;
                end
                S_WE: begin
                    cnt_reg   <= new_cnt_reg;
                    state_reg <= S_OUT;
                end
                S_OUT: begin
                    if (!m_valid_reg || m_ready) begin
                        m_valid_reg <= 1'b1;
                        res_val_reg <= (act_reg == ACT_LOOKUP) ? endv_reg : '0;
                        out_st_reg  <= res_st_reg;
                        out_cnt_reg <= cnt_reg;
                        state_reg   <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // table never holds more than its capacity
    a_cnt_cap: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= CNT_W'(CAPACITY))
        else $error("breakpoint count above capacity");

    // RAM writes only while rewriting the table
    a_we_phase: assert property (@(posedge aclk) disable iff (!aresetn)
        ram_we |-> (state_reg == S_PRE || state_reg == S_SUF || state_reg == S_WB
                    || state_reg == S_WE))
        else $error("RAM write outside rewrite phase");

    // count changes only at the end of a rewrite
    a_cnt_stable: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(state_reg) != S_WE |-> $stable(cnt_reg))
        else $error("count changed outside commit");

    // a rejected or empty assign leaves the count alone
    a_no_commit: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_OUT && res_st_reg != ST_DONE) |=> $stable(cnt_reg))
        else $error("count changed on rejected assign");

    // an accepted beat blocks further input next cycle
    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("second beat taken while busy");

endmodule
`default_nettype wire

// File: verif/tb_interval_map_range_assign_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_interval_map_range_assign_top
// Self-checking bench for the interval map: range assigns and point lookups
// are checked beat by beat against a behavioral breakpoint table kept here.
// ----------------------------------------------------------------------------
module tb_interval_map_range_assign_top;
    import imap_pkg::*;

    localparam int CAP = 64;
    localparam int WATCHDOG_LIMIT = 20000;

    typedef struct packed {
        action_t           action;
        logic signed [31:0] key_begin;
        logic signed [31:0] key_end;
        logic [7:0]        fill_value;
        logic signed [31:0] query_key;
    } map_op_t;

    typedef struct packed {
        logic [7:0] read_value;
        status_t    status;
        logic [6:0] entries_used;
    } map_resp_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic cfg_wr_en = 1'b0;
    logic [7:0] cfg_wr_data = '0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic s_action = 1'b0;
    logic signed [31:0] s_key_begin = '0;
    logic signed [31:0] s_key_end = '0;
    logic [7:0] s_fill_value = '0;
    logic signed [31:0] s_query_key = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic [7:0] m_read_value;
    logic [1:0] m_status;
    logic [6:0] m_entries_used;

    // predictor state
    logic signed [31:0] bp_key[CAP];
    logic [7:0] bp_val[CAP];
    int bp_count;
    logic [7:0] map_default;

    map_op_t pending_ops[$];
    map_resp_t expected_resps[$];
    int error_count = 0;
    int beats_in = 0;
    int beats_out = 0;
    int lookups = 0;
    int fulls = 0;
    int empties = 0;
    int quiet_cycles = 0;
    bit hold_sink = 1'b0;

    always #4 aclk = ~aclk;

    interval_map_range_assign_top DUT (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
        .s_valid(s_valid), .s_ready(s_ready), .s_action(s_action),
        .s_key_begin(s_key_begin), .s_key_end(s_key_end),
        .s_fill_value(s_fill_value), .s_query_key(s_query_key),
        .m_valid(m_valid), .m_ready(m_ready), .m_read_value(m_read_value),
        .m_status(m_status), .m_entries_used(m_entries_used)
    );

    function automatic logic [7:0] value_at_key(logic signed [31:0] k);
        logic [7:0] v;
        v = map_default;
        for (int i = 0; i < bp_count; i++) begin
            if (bp_key[i] <= k) v = bp_val[i];
            else break;
        end
        return v;
    endfunction

    // apply a range assign to the table and return its status
    function automatic status_t assign_range(logic signed [31:0] kb,
                                             logic signed [31:0] ke,
                                             logic [7:0] v);
        logic signed [31:0] wk[CAP+2];
        logic [7:0] wv[CAP+2];
        logic [7:0] end_v, prev_v;
        bit has_prev;
        int n, first;
        if (kb >= ke) return ST_EMPTY;
        end_v = value_at_key(ke);
        n = 0;
        has_prev = 0;
        prev_v = '0;
        for (int i = 0; i < bp_count; i++) begin
            if (bp_key[i] < kb) begin
                wk[n] = bp_key[i]; wv[n] = bp_val[i];
                prev_v = bp_val[i]; has_prev = 1; n++;
            end
        end
        if (!(has_prev && prev_v == v)) begin
            wk[n] = kb; wv[n] = v; n++;
        end
        if (end_v != v) begin
            wk[n] = ke; wv[n] = end_v; n++;
        end
        for (int i = 0; i < bp_count; i++) begin
            if (bp_key[i] > ke) begin
                if (n >= CAP + 2) return ST_FULL;
                wk[n] = bp_key[i]; wv[n] = bp_val[i]; n++;
            end
        end
        first = (n > 0 && wv[0] == map_default) ? 1 : 0;
        if (n - first > CAP) return ST_FULL;
        for (int i = first; i < n; i++) begin
            bp_key[i - first] = wk[i];
            bp_val[i - first] = wv[i];
        end
        bp_count = n - first;
        return ST_DONE;
    endfunction

    function automatic map_resp_t predict_resp(map_op_t op);
        map_resp_t r;
        r.read_value = '0;
        r.status = ST_DONE;
        if (op.action == ACT_ASSIGN) r.status = assign_range(op.key_begin, op.key_end,
                                                           op.fill_value);
        else r.read_value = value_at_key(op.query_key);
        r.entries_used = 7'(bp_count);
        return r;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("MISMATCH beat %0d %s: got %0d expected %0d", beats_out, what, got, want);
        error_count++;
    endtask

    // drive: hold the beat until accepted, then draw a gap
    int src_gap = 0;
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (s_valid && !s_ready) begin
            // hold
        end else begin
            if (s_valid) beats_in++;
            if (src_gap > 0) begin
                src_gap <= src_gap - 1;
                s_valid <= 1'b0;
            end else if (pending_ops.size() > 0) begin
                map_op_t op;
                op = pending_ops.pop_front();
                s_valid <= 1'b1;
                s_action <= op.action;
                s_key_begin <= op.key_begin;
                s_key_end <= op.key_end;
                s_fill_value <= op.fill_value;
                s_query_key <= op.query_key;
                expected_resps.push_back(predict_resp(op));
                if (op.action == ACT_LOOKUP) lookups++;
                src_gap <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 7);
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // monitor: check each result beat, randomly stall the receiver
    int sink_gap = 0;
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                map_resp_t want;
                int gap;
                beats_out++;
                if (expected_resps.size() == 0) begin
                    report_mismatch("unexpected beat", 1, 0);
                end else begin
                    want = expected_resps.pop_front();
                    if (m_read_value !== want.read_value)
                        report_mismatch("read_value", m_read_value, want.read_value);
                    if (m_status !== want.status)
                        report_mismatch("status", m_status, want.status);
                    if (m_entries_used !== want.entries_used)
                        report_mismatch("entries_used", m_entries_used, want.entries_used);
                    if (want.status == ST_FULL) fulls++;
                    if (want.status == ST_EMPTY) empties++;
                end
                gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 7);
                sink_gap <= gap;
                m_ready <= (gap == 0) && !hold_sink;
            end else if (hold_sink) begin
                m_ready <= 1'b0;
            end else if (sink_gap > 0) begin
                sink_gap <= sink_gap - 1;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // watchdog: count cycles without any accepted beat
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || hold_sink
            || (pending_ops.size() == 0 && expected_resps.size() == 0 && !s_valid))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Timeout: no beat accepted for %0d cycles", WATCHDOG_LIMIT);
            $display("Some tests failed");
            $finish;
        end
    end

    function automatic map_op_t mk_assign(logic signed [31:0] kb, logic signed [31:0] ke,
                                          logic [7:0] v);
        map_op_t op;
        op.action = ACT_ASSIGN;
        op.key_begin = kb;
        op.key_end = ke;
        op.fill_value = v;
        op.query_key = $urandom;
        return op;
    endfunction

    function automatic map_op_t mk_lookup(logic signed [31:0] k);
        map_op_t op;
        op.action = ACT_LOOKUP;
        op.key_begin = $urandom;
        op.key_end = $urandom;
        op.fill_value = 8'($urandom);
        op.query_key = k;
        return op;
    endfunction

    // random key: mostly a narrow window so intervals collide, sometimes full range
    function automatic logic signed [31:0] rand_key(int span);
        if ($urandom_range(0, 9) == 0) return $urandom;
        return $signed($urandom_range(0, span)) - span / 2;
    endfunction

    task automatic wait_drained();
        while (pending_ops.size() > 0 || s_valid || expected_resps.size() > 0)
            @(posedge aclk);
        repeat (200) @(posedge aclk);
    endtask

    task automatic write_default(logic [7:0] v);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= v;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        map_default = v;
    endtask

    // queue random items; small windows and few values drive merges and fills
    task automatic add_random(int count, int span, int vals);
        for (int i = 0; i < count; i++) begin
            if ($urandom_range(0, 2) == 0) begin
                pending_ops.push_back(mk_lookup(rand_key(span)));
            end else begin
                logic signed [31:0] a;
                a = rand_key(span);
                if ($urandom_range(0, 15) == 0)
                    pending_ops.push_back(mk_assign(a, a - $urandom_range(0, 3),
                                                    8'($urandom_range(0, vals))));
                else
                    pending_ops.push_back(mk_assign(a, a + 1 + $urandom_range(0, span / 4),
                                                    8'($urandom_range(0, vals))));
            end
        end
    endtask

    initial begin
        bp_count = 0;
        map_default = '0;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: extremes, empty interval, end without predecessor, merges
        write_default(8'd0);
        pending_ops.push_back(mk_lookup(32'sh8000_0000));
        pending_ops.push_back(mk_assign(32'sh8000_0000, 32'sh7fff_ffff, 8'hff));
        pending_ops.push_back(mk_lookup(32'sh8000_0000));
        pending_ops.push_back(mk_lookup(32'sh7fff_ffff));
        pending_ops.push_back(mk_assign(10, 10, 8'h11));
        pending_ops.push_back(mk_assign(20, 5, 8'h11));
        pending_ops.push_back(mk_assign(-100, 100, 8'h5a));
        pending_ops.push_back(mk_assign(-50, 50, 8'h5a));
        pending_ops.push_back(mk_assign(0, 10, 8'h00));
        pending_ops.push_back(mk_lookup(-1));
        pending_ops.push_back(mk_lookup(5));
        pending_ops.push_back(mk_assign(32'sh8000_0000, 32'sh7fff_ffff, 8'h00));
        pending_ops.push_back(mk_lookup(0));
        wait_drained();

        // default changed later, then a table-filling sweep
        write_default(8'hff);
        pending_ops.push_back(mk_assign(1000, 1001, 8'h01));
        for (int i = 0; i < 70; i++)
            pending_ops.push_back(mk_assign(2 * i, 2 * i + 1, 8'(i % 2 + 1)));
        pending_ops.push_back(mk_lookup(7));
        wait_drained();

        // let the result side back up while items keep coming
        hold_sink = 1'b1;
        add_random(20, 400, 7);
        repeat (600) @(posedge aclk);
        hold_sink = 1'b0;
        wait_drained();

        write_default(8'h00);
        add_random(300, 200, 3);
        wait_drained();
        write_default(8'h80);
        add_random(300, 2000, 255);
        wait_drained();
        write_default(8'h03);
        add_random(200, 60, 4);
        wait_drained();

        $display("Covered %0d items in, %0d results out: %0d lookups, %0d empty, %0d full",
                 beats_in, beats_out, lookups, empties, fulls);
        $display("Default values 0x00, 0xff, 0x80, 0x03; long receiver hold-off exercised");
        if (error_count == 0 && expected_resps.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

// File: interval_map_range_assign_top.f
src/imap_pkg.sv
src/imap_ram.sv
src/interval_map_range_assign_top.sv
verif/tb_interval_map_range_assign_top.sv
